@@ rtl/typed_handle_table_engine_macros.svh @@
// Assertion macros for the typed handle table engine checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TYPED_HANDLE_TABLE_ENGINE_MACROS_SVH
`define TYPED_HANDLE_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define THT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define THT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tht_pkg.sv @@
// Shared widths, codes and cell control type for the typed handle table engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tht_pkg;

	localparam int OP_W     = 2;
	localparam int HANDLE_W = 6;
	localparam int KIND_W   = 4;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	localparam int MAX_SLOTS_DEF = 64;
	localparam int KIND_BITS_DEF = 4;

	localparam logic [COUNT_W-1:0] SLOT_LIMIT_RST = 7'd32;
	localparam logic [COUNT_W-1:0] SLOT_LIMIT_MIN = 7'd2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND,
		OP_DELETE,
		OP_NEXT,
		OP_PREV
	} tht_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_NOT_FOUND,
		ST_BAD_HANDLE,
		ST_KIND_MISMATCH,
		ST_FULL
	} tht_status_t;

	typedef struct packed {
		logic wr;
		logic del;
	} tht_cell_ctl_t;

endpackage

@@ rtl/tht_kind_cell.sv @@
// One list position of the kind chain: holds a kind, takes its upper neighbor on delete.
// Depends on tht_pkg.
`timescale 1ns / 1ps

module tht_kind_cell #(
	parameter int KW  = 4,
	parameter int PW  = 6,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tht_pkg::tht_cell_ctl_t ctl,
	input  logic [PW-1:0]         wr_addr,
	input  logic [PW-1:0]         pivot,
	input  logic [PW-1:0]         rd_addr,
	input  logic [KW-1:0]         wr_data,
	input  logic [KW-1:0]         nbr,
	output logic [KW-1:0]         kind_out,
	output logic [KW-1:0]         rd_data
);
	import tht_pkg::*;

	logic [KW-1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
		end else if (ctl.del && (PW'(IDX) >= pivot)) begin
			kind_q <= nbr;
		end else if (ctl.wr && (wr_addr == PW'(IDX))) begin
			kind_q <= wr_data;
		end
	end

	assign kind_out = kind_q;
	assign rd_data  = (rd_addr == PW'(IDX)) ? kind_q : '0;

endmodule

@@ rtl/tht_hmap_cell.sv @@
// One handle of the handle-to-position map; renumbers itself when a lower entry leaves.
// Depends on tht_pkg.
`timescale 1ns / 1ps

module tht_hmap_cell #(
	parameter int PW  = 6,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tht_pkg::tht_cell_ctl_t     ctl,
	input  logic [tht_pkg::HANDLE_W-1:0] handle,
	input  logic [PW-1:0]             wr_data,
	input  logic [PW-1:0]             pivot,
	output logic [PW-1:0]             rd_data
);
	import tht_pkg::*;

	logic [PW-1:0] pos_q;
	logic          sel;

	assign sel = (handle == HANDLE_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.del) begin
			if (sel) begin
				pos_q <= '0;
			end else if (pos_q > pivot) begin
				pos_q <= pos_q - 1'b1;
			end
		end else if (ctl.wr && sel) begin
			pos_q <= wr_data;
		end
	end

	assign rd_data = sel ? pos_q : '0;

endmodule

@@ rtl/typed_handle_table_engine.sv @@
// Channel  | valid / stall         | word
// ---------+-----------------------+----------------------------------------
// command  | cmd_valid / cmd_stall | operation, handle, kind
// result   | res_valid / res_stall | status, position, entries_used
// config   | cfg_wr_en             | cfg_wr_data (slot limit)
//
// Append and delete pass through S_LOOK, S_EXEC and S_DONE from accept to result;
// searches add S_SEARCH, which walks one list position per cycle.
// One command word is in work at a time; the next is taken while a result waits.
// All cells clear at reset; no clearing pass. A stalled result holds in the
// output register; a finished item waits in S_DONE until the register frees.
// Top level of the typed handle table engine; uses tht_pkg, tht_kind_cell, tht_hmap_cell.
`timescale 1ns / 1ps

module typed_handle_table_engine #(
	parameter int MAX_SLOTS = tht_pkg::MAX_SLOTS_DEF,
	parameter int KIND_BITS = tht_pkg::KIND_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [tht_pkg::COUNT_W-1:0]  cfg_wr_data,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [tht_pkg::OP_W-1:0]     operation,
	input  logic [tht_pkg::HANDLE_W-1:0] handle,
	input  logic [tht_pkg::KIND_W-1:0]   kind,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [tht_pkg::STATUS_W-1:0] status,
	output logic [tht_pkg::POS_W-1:0]    position,
	output logic [tht_pkg::COUNT_W-1:0]  entries_used
);
	import tht_pkg::*;

	localparam int HC = (MAX_SLOTS < (1 << HANDLE_W)) ? MAX_SLOTS : (1 << HANDLE_W);
	localparam int NK = (MAX_SLOTS < (1 << COUNT_W)) ? MAX_SLOTS : (1 << COUNT_W);
	localparam int PW = $clog2(NK);
	localparam int CW = $clog2(NK + 1);
	localparam int KW = (KIND_BITS < KIND_W) ? KIND_BITS : KIND_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC,
		S_SEARCH,
		S_DONE
	} state_t;

	state_t               state_q;
	tht_op_t              op_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [KW-1:0]        kind_q;
	logic [COUNT_W-1:0]   slot_limit_q;
	logic [CW-1:0]        used_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        cnt_q;
	logic [PW-1:0]        hp_q;
	logic [PW-1:0]        rpos_q;
	tht_status_t          rstat_q;
	logic                 res_valid_q;
	tht_status_t          status_q;
	logic [POS_W-1:0]     position_q;
	logic [COUNT_W-1:0]   entries_q;

	logic [CW-1:0]        lim;
	logic [CW-1:0]        nidx;
	logic [CW-1:0]        walk_start;
	logic [PW-1:0]        rd_addr;
	logic [PW-1:0]        wr_pos;
	logic [PW-1:0]        ex_pos;
	tht_status_t          ex_stat;
	logic                 append_ok;
	logic                 delete_ok;
	logic                 h_zero;
	logic                 h_over;
	logic                 fwd;
	logic                 kind_hit;
	logic                 search_last;
	logic                 out_free;
	tht_cell_ctl_t        ctl;

	logic [KW-1:0]        kind_out  [NK];
	logic [KW-1:0]        kind_rd_v [NK];
	logic [PW-1:0]        hp_rd_v   [HC];
	logic [KW-1:0]        kind_rd;
	logic [PW-1:0]        hp_rd;

	// kind chain, one cell per list position
	for (genvar i = 0; i < NK; i++) begin : g_kc
		logic [KW-1:0] nbr;
		if (i == NK - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = kind_out[i+1];
		end
		tht_kind_cell #(
			.KW  (KW),
			.PW  (PW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_addr  (wr_pos),
			.pivot    (hp_q),
			.rd_addr  (rd_addr),
			.wr_data  (kind_q),
			.nbr      (nbr),
			.kind_out (kind_out[i]),
			.rd_data  (kind_rd_v[i])
		);
	end

	// handle map, one cell per handle
	for (genvar i = 0; i < HC; i++) begin : g_hc
		tht_hmap_cell #(
			.PW  (PW),
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.handle  (handle_q),
			.wr_data (wr_pos),
			.pivot   (hp_q),
			.rd_data (hp_rd_v[i])
		);
	end

	always_comb begin
		kind_rd = '0;
		for (int i = 0; i < NK; i++) begin
			kind_rd |= kind_rd_v[i];
		end
		hp_rd = '0;
		for (int i = 0; i < HC; i++) begin
			hp_rd |= hp_rd_v[i];
		end
	end

	always_comb begin
		if (slot_limit_q < SLOT_LIMIT_MIN) begin
			lim = CW'(SLOT_LIMIT_MIN);
		end else if (32'(slot_limit_q) > NK) begin
			lim = CW'(NK);
		end else begin
			lim = CW'(slot_limit_q);
		end
	end

	assign wr_pos   = PW'(used_q);
	assign h_zero   = (handle_q == '0);
	assign h_over   = (32'(handle_q) >= 32'(lim));
	assign fwd      = (op_q == OP_NEXT);
	assign kind_hit = (kind_rd == kind_q);

	always_comb begin
		ex_stat   = ST_OK;
		ex_pos    = '0;
		append_ok = 1'b0;
		delete_ok = 1'b0;
		unique case (op_q) inside
			OP_APPEND: begin
				if (h_zero || h_over || hp_q != '0) begin
					ex_stat = ST_BAD_HANDLE;
				end else if (kind_q == '0) begin
					ex_stat = ST_KIND_MISMATCH;
				end else if (used_q >= lim) begin
					ex_stat = ST_FULL;
				end else begin
					append_ok = 1'b1;
					ex_pos    = wr_pos;
				end
			end
			OP_DELETE: begin
				if (h_zero || h_over) begin
					ex_stat = ST_BAD_HANDLE;
				end else if (hp_q == '0 || 32'(hp_q) >= 32'(used_q)) begin
					ex_stat = ST_NOT_FOUND;
				end else if (!kind_hit) begin
					ex_stat = ST_KIND_MISMATCH;
				end else begin
					delete_ok = 1'b1;
					ex_pos    = hp_q;
				end
			end
			OP_NEXT, OP_PREV: begin
				if (h_over) begin
					ex_stat = ST_BAD_HANDLE;
				end else if (used_q <= CW'(1)) begin
					ex_stat = ST_NOT_FOUND;
				end
			end
		endcase
	end

	always_comb begin
		if (h_zero) begin
			walk_start = fwd ? CW'(1) : used_q;
		end else begin
			walk_start = CW'(hp_q);
		end
		if (fwd) begin
			nidx = (32'(idx_q) + 1 >= 32'(used_q)) ? CW'(1) : idx_q + CW'(1);
		end else begin
			nidx = (idx_q <= CW'(1) || idx_q > used_q) ? used_q - CW'(1) : idx_q - CW'(1);
		end
	end

	assign rd_addr     = (state_q == S_SEARCH) ? PW'(nidx) : hp_q;
	assign search_last = (32'(cnt_q) + 2 == 32'(used_q));
	assign ctl.wr      = (state_q == S_EXEC) && append_ok;
	assign ctl.del     = (state_q == S_EXEC) && delete_ok;
	assign out_free    = !res_valid_q || !res_stall;
	assign cmd_stall   = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_APPEND;
			res_valid_q  <= 1'b0;
			used_q       <= CW'(1);
			slot_limit_q <= SLOT_LIMIT_RST;
		end else begin
			if (cfg_wr_en) begin
				slot_limit_q <= cfg_wr_data;
			end
			if (res_valid_q && !res_stall && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q     <= tht_op_t'(operation);
						handle_q <= handle;
						kind_q   <= kind[KW-1:0];
						state_q  <= S_LOOK;
					end
				end
				S_LOOK: begin
					hp_q    <= hp_rd;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					rstat_q <= ex_stat;
					rpos_q  <= ex_pos;
					if (append_ok) begin
						used_q <= used_q + CW'(1);
					end
					if (delete_ok) begin
						used_q <= used_q - CW'(1);
					end
					if ((op_q == OP_NEXT || op_q == OP_PREV) && ex_stat == ST_OK) begin
						idx_q   <= walk_start;
						cnt_q   <= '0;
						state_q <= S_SEARCH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SEARCH: begin
					if (kind_hit) begin
						rstat_q <= ST_OK;
						rpos_q  <= PW'(nidx);
						state_q <= S_DONE;
					end else if (search_last) begin
						rstat_q <= ST_NOT_FOUND;
						rpos_q  <= '0;
						state_q <= S_DONE;
					end else begin
						idx_q <= nidx;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						status_q    <= rstat_q;
						position_q  <= POS_W'(rpos_q);
						entries_q   <= COUNT_W'(used_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign position     = position_q;
	assign entries_used = entries_q;

endmodule

@@ rtl/tht_checker.sv @@
// Port-level checker for the typed handle table engine, bound to the top level.
// Depends on tht_pkg and typed_handle_table_engine_macros.svh.
`timescale 1ns / 1ps
`include "typed_handle_table_engine_macros.svh"

module tht_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_stall,
	input logic                         res_valid,
	input logic                         res_stall,
	input logic [tht_pkg::STATUS_W-1:0] status,
	input logic [tht_pkg::POS_W-1:0]    position,
	input logic [tht_pkg::COUNT_W-1:0]  entries_used
);
	import tht_pkg::*;

	`THT_ASSERT_IMPL(a_pos_zero, clk, arst_n, res_valid && status != ST_OK, position == '0, "position set on failed word")
	`THT_ASSERT_IMPL(a_used_nonzero, clk, arst_n, res_valid, entries_used != '0, "null entry lost")
	`THT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(status) && $stable(position) && $stable(entries_used), "stalled result changed")
	`THT_ASSERT_NEXT(a_one_word, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall, "second word taken while busy")

endmodule

bind typed_handle_table_engine tht_checker u_tht_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd_valid),
	.cmd_stall    (cmd_stall),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.status       (status),
	.position     (position),
	.entries_used (entries_used)
);
